// ===== sv/dbr_pkg.sv =====
// Shared types, constants and helpers for the queue-pair doorbell ring.
package dbr_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 1024;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   // Field widths
   localparam int QNUM_W   = 16;
   localparam int CMD_W    = 8;
   localparam int DONE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int WORD_W   = 64;
   localparam int DB_IDX_W = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_NUMBER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBMIT_CMD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPLETE_CMD  = 2'd2;

   localparam logic [CMD_W-1:0] SUBMIT_CMD_RESET   = 8'd0;
   localparam logic [CMD_W-1:0] COMPLETE_CMD_RESET = 8'd1;

   // Item modes
   localparam logic MODE_SUBMIT = 1'b0;
   localparam logic MODE_POLL   = 1'b1;

   localparam logic [DONE_W-1:0] DONE_OK = 8'h03;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_SUBMITTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ERROR     = 3'd4;

   typedef struct packed {
      logic              mode;
      logic              entry_phase;
      logic [DONE_W-1:0] done_status;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic                doorbell_valid;
      logic [WORD_W-1:0]   doorbell_word;
   } rsp_type;

   typedef struct packed {
      logic [QNUM_W-1:0] queue_number;
      logic [CMD_W-1:0]  submit_cmd;
      logic [CMD_W-1:0]  complete_cmd;
   } cfg_type;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx >= IDX_LAST) res = '0;
      else                 res = idx + 1'b1;
      return res;
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

   // priority 63..48, index 47..32, spare 31..24, command 23..16, queue 15..0
   function automatic logic [WORD_W-1:0] pack_doorbell(
      input logic [QNUM_W-1:0] qnum,
      input logic [CMD_W-1:0]  cmd,
      input logic [IDX_W-1:0]  idx
   );
      logic [DB_IDX_W-1:0] idx16;
      idx16 = DB_IDX_W'(idx);
      return {16'h0000, idx16, 8'h00, cmd, qnum};
   endfunction

endpackage

// ===== sv/dbr_csr.sv =====
// Configuration registers of the doorbell ring.
module dbr_csr import dbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUEUE_NUMBER: cfg_in.queue_number = csr_wdata[QNUM_W-1:0];
            CSR_SUBMIT_CMD:   cfg_in.submit_cmd   = csr_wdata[CMD_W-1:0];
            CSR_COMPLETE_CMD: cfg_in.complete_cmd = csr_wdata[CMD_W-1:0];
            default:          cfg_in = cfg_ff; // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_number <= '0;
         cfg_ff.submit_cmd   <= SUBMIT_CMD_RESET;
         cfg_ff.complete_cmd <= COMPLETE_CMD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/dbr_in_stage.sv =====
// Input register stage: holds one request item until the ring logic takes it.
module dbr_in_stage import dbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    advance,
   output logic    stage_valid,
   output req_type stage_item
);

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    load;

   // Load when empty or when the held item moves on this cycle
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ===== sv/dbr_ring.sv =====
// Ring pointers, phase tracking and result/doorbell formation.
module dbr_ring import dbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] shead_ff, shead_in;
   logic [IDX_W-1:0] chead_ff, chead_in;
   logic             phase_ff, phase_in;
   logic             full_ff, full_in;
   logic [IDX_W-1:0] tail_nxt;
   logic [IDX_W-1:0] chead_nxt;

   assign tail_nxt  = wrap_next(tail_ff);
   assign chead_nxt = wrap_next(chead_ff);

   always_comb begin
      tail_in  = tail_ff;
      shead_in = shead_ff;
      chead_in = chead_ff;
      phase_in = phase_ff;
      full_in  = full_ff;
      result   = '0;
      if (item.mode == MODE_SUBMIT) begin
         result.slot_index = to_slot(tail_ff);
         if (full_ff) begin
            result.status = ST_BUSY;
         end else begin
            result.status         = ST_SUBMITTED;
            result.doorbell_valid = 1'b1;
            result.doorbell_word  = pack_doorbell(cfg.queue_number, cfg.submit_cmd,
                                                  tail_nxt);
            tail_in = tail_nxt;
            if (tail_nxt == shead_ff) begin
               full_in = 1'b1;
            end
         end
      end else begin
         result.slot_index = to_slot(chead_ff);
         if (item.entry_phase != phase_ff) begin
            result.status = ST_NOTHING;
         end else if (item.done_status != DONE_OK) begin
            result.status = ST_ERROR;
         end else begin
            result.status         = ST_TAKEN;
            result.doorbell_valid = 1'b1;
            result.doorbell_word  = pack_doorbell(cfg.queue_number, cfg.complete_cmd,
                                                  chead_nxt);
            full_in  = 1'b0;
            chead_in = chead_nxt;
            shead_in = chead_nxt;
            // phase flips each time the completion head wraps
            if (chead_nxt == '0) begin
               phase_in = !phase_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '0;
         shead_ff <= '0;
         chead_ff <= '0;
         phase_ff <= 1'b1;
         full_ff  <= 1'b0;
      end else if (fire) begin
         tail_ff  <= tail_in;
         shead_ff <= shead_in;
         chead_ff <= chead_in;
         phase_ff <= phase_in;
         full_ff  <= full_in;
      end
   end

endmodule

// ===== sv/dbr_out_stage.sv =====
// Result register stage facing the response channel.
module dbr_out_stage import dbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    stage_valid,
   input  rsp_type result,
   output logic    advance,
   output logic    fire,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   // Room when empty or the held result leaves this cycle
   assign advance  = !valid_ff || !rsp_stall;
   assign fire     = advance && stage_valid;
   assign valid_in = advance ? stage_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== sv/queue_pair_doorbell_ring_top.sv =====
// Top level of the queue-pair doorbell ring.
//
// Usage:
//   req channel (req_valid / req_stall / req_item) carries one item per
//   submit (mode 0) or completion poll (mode 1). rsp channel carries exactly
//   one result item per request: status, ring slot and the doorbell word.
//   csr_wr_en / csr_index / csr_wdata write queue number (0), submit
//   doorbell command (1) and completion doorbell command (2); other indices
//   are ignored. Write only while the block is idle.
// Timing:
//   An item accepted on the req channel is held in the input register; its
//   result is captured in the result register, raising rsp_valid, as soon
//   as that register has room. One item per cycle sustained while rsp_stall
//   is low: the pointer update, phase compare and doorbell pack are one
//   shallow stage between the input and result registers.
// Reset (synchronous): both stages empty, tail/heads zero, expected phase 1,
//   full flag clear, registers back to 0 / 0 / 1.
// Stall: while rsp_stall holds a result, the input register keeps one more
//   item; req_stall rises once both are occupied. Ring state only moves when
//   an item enters the result register, so stalls never lose or repeat work.
module queue_pair_doorbell_ring_top import dbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    advance;
   logic    fire;
   logic    stage_valid;
   req_type stage_item;
   rsp_type result;

   dbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dbr_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   // pointer state updates on the same edge the result is captured
   dbr_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage_item),
      .cfg    (cfg),
      .result (result)
   );

   dbr_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .result      (result),
      .advance     (advance),
      .fire        (fire),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== sv/dbr_checker.sv =====
// Port-level checker for the doorbell ring, bound to the top level.
module dbr_checker import dbr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_item,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   logic rsp_acc;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // a submit following a submit starts at the tail the last doorbell gave
   a_tail_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_item.status == ST_SUBMITTED) ##1
      (rsp_acc && (rsp_item.status == ST_SUBMITTED || rsp_item.status == ST_BUSY))
      |-> rsp_item.slot_index == $past(rsp_item.doorbell_word[32 +: SLOT_W]))
      else $error("submit slot does not follow previous tail");

   // a full ring cannot take a submit until a completion frees it
   a_busy_sticks: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_item.status == ST_BUSY) ##1 rsp_acc
      |-> rsp_item.status != ST_SUBMITTED)
      else $error("submit accepted right after busy");

endmodule

bind queue_pair_doorbell_ring_top dbr_checker u_dbr_checker (.*);
